@@ rtl/core/ccc_pkg.sv @@
// Package for the circle-circle collision core.
// Shared field widths, pipeline constants and the result word type.
// No dependencies.
package ccc_pkg;

  localparam int unsigned CoordW        = 24;
  localparam int unsigned RadiusW       = 23;
  localparam int unsigned DiffW         = 25;
  localparam int unsigned SqW           = 50;
  localparam int unsigned RsumW         = 24;
  localparam int unsigned DepthW        = 24;
  localparam int unsigned NormW         = 16;
  localparam int unsigned RadW          = 64;
  localparam int unsigned RootW         = 32;
  localparam int unsigned SqrtStages    = 32;
  localparam int unsigned NormSat       = 32767;
  localparam int unsigned NormFracBitsDef = 14;

  typedef struct packed {
    logic                    hit;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic [DepthW-1:0]       depth;
  } res_t;

endpackage

@@ rtl/core/ccc_in_if.sv @@
// Input channel of the circle-circle collision core.
// Carries one circle pair per word; depends on ccc_pkg.
interface ccc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ccc_pkg::CoordW-1:0]   center_a_x;
  logic signed [ccc_pkg::CoordW-1:0]   center_a_y;
  logic        [ccc_pkg::RadiusW-1:0]  radius_a;
  logic signed [ccc_pkg::CoordW-1:0]   center_b_x;
  logic signed [ccc_pkg::CoordW-1:0]   center_b_y;
  logic        [ccc_pkg::RadiusW-1:0]  radius_b;

  modport source (
    output valid, center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
    input  ready
  );
  modport sink (
    input  valid, center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
    output ready
  );
endinterface

@@ rtl/core/ccc_out_if.sv @@
// Output channel of the circle-circle collision core.
// Carries one collision result per word; depends on ccc_pkg.
interface ccc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [ccc_pkg::NormW-1:0]  normal_x;
  logic signed [ccc_pkg::NormW-1:0]  normal_y;
  logic        [ccc_pkg::DepthW-1:0] depth;

  modport source (
    output valid, hit, normal_x, normal_y, depth,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, depth,
    output ready
  );
endinterface

@@ rtl/core/ccc_isqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside; depends on ccc_pkg.
module ccc_isqrt_pipe #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [ccc_pkg::RadW-1:0]    rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [ccc_pkg::RootW-1:0]   root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned N = ccc_pkg::SqrtStages;
  localparam int unsigned W = ccc_pkg::RadW;

  logic          v_q    [N];
  logic [W-1:0]  rem_q  [N];
  logic [W-1:0]  root_q [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (W - 2 - 2 * k);
    logic              v_in;
    logic [W-1:0]      rem_in, root_in, rem_d, root_d;
    logic [SIDE_W-1:0] side_in;
    logic [W:0]        trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial  = {1'b0, root_in} + {1'b0, Bit};
    assign take   = {1'b0, rem_in} >= trial;
    assign rem_d  = take ? (rem_in - trial[W-1:0]) : rem_in;
    assign root_d = take ? ((root_in >> 1) + Bit) : (root_in >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1][ccc_pkg::RootW-1:0];
  assign side_o  = side_q[N-1];

endmodule

@@ rtl/core/ccc_div_pipe.sv @@
// Pipelined restoring divider for both normal components, one quotient bit per stage.
// Shares the divisor between the two lanes; depends on ccc_pkg.
module ccc_div_pipe #(
  parameter int unsigned NORMAL_FRAC_BITS = ccc_pkg::NormFracBitsDef,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  logic [NORMAL_FRAC_BITS+32:0]      num_x_i,
  input  logic [NORMAL_FRAC_BITS+32:0]      num_y_i,
  input  logic [ccc_pkg::RootW-1:0]         den_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [NORMAL_FRAC_BITS:0]         q_x_o,
  output logic [NORMAL_FRAC_BITS:0]         q_y_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned NF = NORMAL_FRAC_BITS;
  localparam int unsigned NW = NF + 33;
  localparam int unsigned N  = NF + 1;
  localparam int unsigned DW = ccc_pkg::RootW;

  logic              v_q    [N];
  logic [NW-1:0]     rx_q   [N];
  logic [NW-1:0]     ry_q   [N];
  logic [NF:0]       qx_q   [N];
  logic [NF:0]       qy_q   [N];
  logic [DW-1:0]     den_q  [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int unsigned Sh = NF - i;
    logic              v_in;
    logic [NW-1:0]     rx_in, ry_in, dsh;
    logic [NF:0]       qx_in, qy_in;
    logic [DW-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic              take_x, take_y;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rx_in   = num_x_i;
      assign ry_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rx_in   = rx_q[i-1];
      assign ry_in   = ry_q[i-1];
      assign qx_in   = qx_q[i-1];
      assign qy_in   = qy_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dsh    = NW'(den_in) << Sh;
    assign take_x = rx_in >= dsh;
    assign take_y = ry_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[i]   <= take_x ? (rx_in - dsh) : rx_in;
        ry_q[i]   <= take_y ? (ry_in - dsh) : ry_in;
        qx_q[i]   <= qx_in | ((NF+1)'(take_x) << Sh);
        qy_q[i]   <= qy_in | ((NF+1)'(take_y) << Sh);
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign q_x_o   = qx_q[N-1];
  assign q_y_o   = qy_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

@@ rtl/core/circle_circle_collision_core.sv @@
// Top level of the circle-circle collision core.
// Depends on ccc_pkg, ccc_in_if, ccc_out_if, ccc_isqrt_pipe and ccc_div_pipe.

// The core takes one circle pair per word and returns one result word per pair, in
// order. It accepts a new word in every clock cycle while the skid register is empty.
// Each word passes through registered stages for the differences, squares and
// overlap compare, the square root pipeline (one root bit per stage), a stage that
// rounds the distance and forms the dividends, the two normal divisions, which
// produce one quotient bit per stage, and the output register. A skid register
// behind the output register keeps input ready high while only the output register
// holds a waiting result, so ready is a registered signal. The hit test
// compares the exact squared distance against the squared radii sum. When the two
// centres coincide the normal is reported as zero and the depth equals the radii sum.
module circle_circle_collision_core #(
  parameter int unsigned NORMAL_FRAC_BITS = ccc_pkg::NormFracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccc_in_if.sink    in_i,
  ccc_out_if.source out_o
);

  localparam int unsigned NF   = NORMAL_FRAC_BITS;
  localparam int unsigned NW   = NF + 33;
  localparam int unsigned DfW  = ccc_pkg::DiffW;
  localparam int unsigned SqW  = ccc_pkg::SqW;
  localparam int unsigned RsW  = ccc_pkg::RsumW;
  localparam int unsigned RtW  = ccc_pkg::RootW;
  localparam int unsigned QW   = (NF + 1 > 16) ? NF + 1 : 16;
  localparam logic [QW-1:0] Lim = (NF >= 15) ? QW'(ccc_pkg::NormSat) : (QW'(1) << NF);
  localparam int unsigned SqSideW  = 3 + 2 * DfW + RsW;
  localparam int unsigned DivSideW = 4 + ccc_pkg::DepthW;

  // The whole pipeline moves together; it only holds while the skid register is full.
  logic adv;
  logic skid_v_q;
  assign adv        = !skid_v_q;
  assign in_i.ready = adv;

  // Stage 1: coordinate differences and radii sum.
  logic                  v1_q;
  logic signed [DfW-1:0] dx_q, dy_q;
  logic [RsW-1:0]        rsum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= {in_i.center_b_x[23], in_i.center_b_x} - {in_i.center_a_x[23], in_i.center_a_x};
      dy_q    <= {in_i.center_b_y[23], in_i.center_b_y} - {in_i.center_a_y[23], in_i.center_a_y};
      rsum1_q <= {1'b0, in_i.radius_a} + {1'b0, in_i.radius_b};
    end
  end

  // Stage 2: magnitudes and the three squares.
  logic            v2_q, sx2_q, sy2_q;
  logic [DfW-1:0]  adx2_q, ady2_q, adx_d, ady_d;
  logic [SqW-1:0]  sqx_q, sqy_q;
  logic [2*RsW-1:0] rr_q;
  logic [RsW-1:0]  rsum2_q;

  assign adx_d = dx_q[DfW-1] ? (~dx_q + DfW'(1)) : dx_q;
  assign ady_d = dy_q[DfW-1] ? (~dy_q + DfW'(1)) : dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx2_q   <= dx_q[DfW-1];
      sy2_q   <= dy_q[DfW-1];
      adx2_q  <= adx_d;
      ady2_q  <= ady_d;
      sqx_q   <= {25'b0, adx_d} * {25'b0, adx_d};
      sqy_q   <= {25'b0, ady_d} * {25'b0, ady_d};
      rr_q    <= {24'b0, rsum1_q} * {24'b0, rsum1_q};
      rsum2_q <= rsum1_q;
    end
  end

  // Stage 3: squared distance and the exact overlap compare.
  logic                     v3_q;
  logic [ccc_pkg::RadW-1:0] rad3_q;
  logic [SqSideW-1:0]       side3_q;
  logic [SqW-1:0]           d2;
  logic                     hit3;

  assign d2   = sqx_q + sqy_q;
  assign hit3 = d2 < {2'b0, rr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad3_q  <= {d2, 14'b0};
      side3_q <= {hit3, sx2_q, sy2_q, adx2_q, ady2_q, rsum2_q};
    end
  end

  // Square root of the squared distance in Q.14, giving the distance in Q.7.
  logic               sq_v;
  logic [RtW-1:0]     s;
  logic [SqSideW-1:0] sq_side;

  ccc_isqrt_pipe #(
    .SIDE_W (SqSideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v3_q),
    .rad_i   (rad3_q),
    .side_i  (side3_q),
    .valid_o (sq_v),
    .root_o  (s),
    .side_o  (sq_side)
  );

  // Post-root stage: rounded distance, depth and the two dividends.
  logic           p_hit, p_sx, p_sy;
  logic [DfW-1:0] p_adx, p_ady;
  logic [RsW-1:0] p_rsum, dist_rnd, depth_d;
  logic [RtW:0]   s_rnd;

  assign {p_hit, p_sx, p_sy, p_adx, p_ady, p_rsum} = sq_side;
  assign s_rnd    = {1'b0, s} + (RtW+1)'(64);
  // The rounded distance can only pass the radii sum by rounding; clamp it there.
  assign dist_rnd = (s_rnd[RtW:7] > {2'b0, p_rsum}) ? p_rsum : s_rnd[RsW+6:7];
  assign depth_d  = p_rsum - dist_rnd;

  logic                v4_q;
  logic [NW-1:0]       numx_q, numy_q;
  logic [RtW-1:0]      s4_q;
  logic [DivSideW-1:0] side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q  <= (NW'(p_adx) << (NF + 7)) + NW'(s >> 1);
      numy_q  <= (NW'(p_ady) << (NF + 7)) + NW'(s >> 1);
      s4_q    <= s;
      side4_q <= {p_hit, (s != '0), p_sx, p_sy, depth_d};
    end
  end

  // Normal components: rounded quotient of each magnitude by the distance.
  logic                v5;
  logic [NF:0]         qx, qy;
  logic [DivSideW-1:0] side5;

  ccc_div_pipe #(
    .NORMAL_FRAC_BITS (NF),
    .SIDE_W           (DivSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v4_q),
    .num_x_i (numx_q),
    .num_y_i (numy_q),
    .den_i   (s4_q),
    .side_i  (side4_q),
    .valid_o (v5),
    .q_x_o   (qx),
    .q_y_o   (qy),
    .side_o  (side5)
  );

  // Saturate a quotient to one (and to the field range), apply the sign, and zero
  // it on a miss or when the centres coincide.
  function automatic logic [15:0] norm_fix(input logic [NF:0] q, input logic neg,
                                           input logic keep);
    logic [QW-1:0] qe;
    logic [QW-1:0] m;
    logic [15:0]   r;
    qe = QW'(q);
    m  = (qe > Lim) ? Lim : qe;
    r  = m[15:0];
    if (neg) begin
      r = ~r + 16'd1;
    end
    if (!keep) begin
      r = '0;
    end
    return r;
  endfunction

  logic                f_hit, f_nz, f_sx, f_sy;
  logic [ccc_pkg::DepthW-1:0] f_depth;
  ccc_pkg::res_t       res_d;

  assign {f_hit, f_nz, f_sx, f_sy, f_depth} = side5;
  assign res_d.hit      = f_hit;
  assign res_d.normal_x = norm_fix(qx, f_sx, f_hit && f_nz);
  assign res_d.normal_y = norm_fix(qy, f_sy, f_hit && f_nz);
  assign res_d.depth    = f_hit ? f_depth : '0;

  // Output register with a skid register behind it.
  logic          out_v_q;
  ccc_pkg::res_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (v5) begin
      out_v_q <= 1'b1;
      if (out_v_q && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_o.ready) begin
        out_q <= skid_q;
      end
    end else if (v5) begin
      if (out_v_q && !out_o.ready) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.hit      = out_q.hit;
  assign out_o.normal_x = out_q.normal_x;
  assign out_o.normal_y = out_q.normal_y;
  assign out_o.depth    = out_q.depth;

endmodule

@@ verif/tb_circle_circle_collision_core.sv @@
// Self-checking testbench for the circle-circle collision core.
// Drives circle pairs through ccc_in_if, checks results from ccc_out_if in order.
// Depends on ccc_pkg, ccc_in_if, ccc_out_if and circle_circle_collision_core.
module tb_circle_circle_collision_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam int unsigned NFB = NormFracBitsDef;

  // One pending circle pair.
  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic [RadiusW-1:0]       ra;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [RadiusW-1:0]       rb;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ccc_in_if  in_if ();
  ccc_out_if out_if ();

  circle_circle_collision_core #(.NORMAL_FRAC_BITS(NFB)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  pair_t pending_pairs[$];
  res_t  expected_results[$];
  int    mismatches = 0;
  int    hits_seen = 0;
  int    words_seen = 0;
  bit    stim_done = 1'b0;

  // Bitwise integer square root, floor of sqrt(x).
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // One component of the unit normal, rounded and saturated.
  function automatic logic signed [NormW-1:0] normal_comp(longint d, logic [63:0] s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (d < 0) ? -d : d;
    if (s == 0) return '0;
    q = ((mag << (NFB + 7)) + (s >> 1)) / s;
    if (q > (64'd1 << NFB)) q = 64'd1 << NFB;
    if (q > NormSat) q = NormSat;
    if (d < 0) q = -q;
    return q[NormW-1:0];
  endfunction

  function automatic res_t collide(pair_t p);
    res_t r;
    longint dx;
    longint dy;
    logic [63:0] d2;
    logic [63:0] rsum;
    logic [63:0] s;
    logic [63:0] dist_rnd;
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    d2 = dx * dx + dy * dy;
    rsum = 64'(p.ra) + 64'(p.rb);
    r = '0;
    if (d2 >= rsum * rsum) return r;
    s = floor_sqrt(d2 << 14);
    dist_rnd = (s + 64) >> 7;
    if (dist_rnd > rsum) dist_rnd = rsum;
    r.hit = 1'b1;
    r.normal_x = normal_comp(dx, s);
    r.normal_y = normal_comp(dy, s);
    r.depth = DepthW'(rsum - dist_rnd);
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom);
      1: return CoordW'($urandom_range(0, 8191)) - 24'sd4096;
      default: return CoordW'($urandom_range(0, 255)) - 24'sd128;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 3);
    p.ax = rand_coord(mode);
    p.ay = rand_coord(mode);
    if (mode == 0) begin
      p.bx = rand_coord(0);
      p.by = rand_coord(0);
      p.ra = RadiusW'($urandom);
      p.rb = RadiusW'($urandom);
    end else begin
      // Near pairs so that most of these words overlap.
      p.bx = p.ax + rand_coord(mode);
      p.by = p.ay + rand_coord(mode);
      p.ra = RadiusW'($urandom_range(0, mode == 1 ? 6000 : 200));
      p.rb = RadiusW'($urandom_range(0, mode == 1 ? 6000 : 200));
      if ($urandom_range(0, 9) == 0) begin
        p.bx = p.ax;
        p.by = p.ay;
      end
    end
    return p;
  endfunction

  function automatic pair_t mk(int ax, int ay, int ra, int bx, int by, int rb);
    pair_t p;
    p.ax = CoordW'(ax); p.ay = CoordW'(ay); p.ra = RadiusW'(ra);
    p.bx = CoordW'(bx); p.by = CoordW'(by); p.rb = RadiusW'(rb);
    return p;
  endfunction

  // Handshakes as seen at the rising edge, used by the falling-edge processes.
  logic in_acc_q = 1'b0;
  logic out_acc_q = 1'b0;
  always @(posedge clk_i) begin
    in_acc_q  <= in_if.valid && in_if.ready;
    out_acc_q <= out_if.valid && out_if.ready;
  end

  // Driver: presents words from the pending queue with random gaps.
  int send_gap = 0;
  initial begin
    in_if.valid = 1'b0;
    {in_if.center_a_x, in_if.center_a_y, in_if.radius_a,
     in_if.center_b_x, in_if.center_b_y, in_if.radius_b} = '0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc_q) begin
        expected_results.push_back(collide(pending_pairs.pop_front()));
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (in_acc_q || !in_if.valid) begin
        if (send_gap == 0 && pending_pairs.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.center_a_x <= pending_pairs[0].ax;
          in_if.center_a_y <= pending_pairs[0].ay;
          in_if.radius_a <= pending_pairs[0].ra;
          in_if.center_b_x <= pending_pairs[0].bx;
          in_if.center_b_y <= pending_pairs[0].by;
          in_if.radius_b <= pending_pairs[0].rb;
        end else begin
          in_if.valid <= 1'b0;
          if (send_gap > 0) send_gap = send_gap - 1;
        end
      end
    end
  end

  // Monitor: compares each accepted result word.
  int recv_gap = 0;
  initial out_if.ready = 1'b0;

  always @(posedge clk_i) begin
    res_t got;
    res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.hit, out_if.normal_x, out_if.normal_y, out_if.depth};
      words_seen++;
      if (got.hit) hits_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word %p", $realtime, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          $display("%0t: expected hit=%0d nx=%0d ny=%0d depth=%0d, got hit=%0d nx=%0d ny=%0d depth=%0d",
                   $realtime, exp_r.hit, exp_r.normal_x, exp_r.normal_y, exp_r.depth,
                   got.hit, got.normal_x, got.normal_y, got.depth);
        end
      end
    end
  end

  // Ready pattern of the receiver: a random stall after each word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc_q) begin
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (out_acc_q || !out_if.ready) begin
        if (recv_gap == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          recv_gap = recv_gap - 1;
        end
      end
    end
  end

  initial begin
    pending_pairs.push_back(mk(0, 0, 100, 50, 0, 100));
    pending_pairs.push_back(mk(0, 0, 100, 0, 0, 100));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(0, 0, 0, 1, 0, 0));
    pending_pairs.push_back(mk(0, 0, 100, 300, 400, 400));
    pending_pairs.push_back(mk(0, 0, 100, 300, 400, 401));
    pending_pairs.push_back(mk(0, 0, 1, 0, 1, 1));
    pending_pairs.push_back(mk(0, 0, 3, 1, 1, 0));
    pending_pairs.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607));
    pending_pairs.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608, 8388607));
    pending_pairs.push_back(mk(8388607, -8388608, 8388607, -8388608, 8388607, 0));
    pending_pairs.push_back(mk(100, 100, 50, 100, 20, 50));
    pending_pairs.push_back(mk(100, 100, 50, 20, 100, 50));
    pending_pairs.push_back(mk(-5, -7, 8388607, -5, -7, 8388607));
    pending_pairs.push_back(mk(0, 0, 8388607, 1, 1, 8388607));
    pending_pairs.push_back(mk(0, 0, 2, 1, 1, 0));
    pending_pairs.push_back(mk(-1, -1, 5, 2, 3, 1));
    for (int i = 0; i < 900; i++) pending_pairs.push_back(rand_pair());
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pending_pairs.size() == 0 && !in_if.valid);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk_i);
    $display("Checked %0d result words, %0d of them hits, incl. coincident and extreme pairs.",
             words_seen, hits_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/ccc_pkg.sv
rtl/core/ccc_in_if.sv
rtl/core/ccc_out_if.sv
rtl/core/ccc_isqrt_pipe.sv
rtl/core/ccc_div_pipe.sv
rtl/core/circle_circle_collision_core.sv
verif/tb_circle_circle_collision_core.sv
